// ===== design/lsta_pkg.sv =====
// shared types, constants and hop tables for the led snake trail animator
`default_nettype none

package lsta_pkg;

    // digit geometry and levels
    localparam int NUM_SEGMENTS             = 7;
    localparam int DEF_LEDS_PER_SEGMENT     = 4;
    localparam int CFG_W                    = 8;
    localparam int LEVEL_W                  = 8;
    localparam int INDEX_W                  = 9;
    localparam int SEG_W                    = 3;
    localparam int POS_W                    = 4;
    localparam logic [LEVEL_W-1:0] FULL_LEVEL = 8'hFF;
    localparam logic [SEG_W-1:0]   SEG_NONE   = 3'd7;

    // next head segment and entry direction
    typedef struct packed {
        logic [SEG_W-1:0] seg;
        logic             up;
    } hop_t;

    // controller to datapath
    typedef struct packed {
        logic load_head;
        logic shift;
    } lsta_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic at_last;
        logic out_free;
    } lsta_stat_t;

    // neighbor when leaving a segment at its top end
    function automatic hop_t fwd_hop(input logic [SEG_W-1:0] seg, input logic pick);
        hop_t h;
        case (seg)
            3'd0:    h = '{seg: pick ? 3'd3 : 3'd1, up: 1'b0};
            3'd1:    h = '{seg: pick ? 3'd3 : 3'd0, up: 1'b0};
            3'd2:    h = '{seg: 3'd4, up: 1'b0};
            3'd3:    h = '{seg: pick ? 3'd0 : 3'd1, up: 1'b0};
            3'd4:    h = '{seg: 3'd2, up: 1'b0};
            3'd5:    h = '{seg: 3'd0, up: 1'b1};
            3'd6:    h = '{seg: pick ? 3'd2 : 3'd1, up: 1'b1};
            default: h = '{seg: 3'd0, up: 1'b1};
        endcase
        return h;
    endfunction

    // neighbor when leaving a segment at its bottom end
    function automatic hop_t rev_hop(input logic [SEG_W-1:0] seg, input logic pick);
        hop_t h;
        case (seg)
            3'd0:    h = '{seg: 3'd5, up: 1'b0};
            3'd1:    h = '{seg: pick ? 3'd6 : 3'd2, up: ~pick};
            3'd2:    h = '{seg: pick ? 3'd6 : 3'd1, up: ~pick};
            3'd3:    h = '{seg: 3'd4, up: 1'b1};
            3'd4:    h = '{seg: 3'd3, up: 1'b1};
            3'd5:    h = '{seg: 3'd6, up: 1'b1};
            3'd6:    h = '{seg: 3'd5, up: 1'b1};
            default: h = '{seg: 3'd0, up: 1'b1};
        endcase
        return h;
    endfunction

endpackage

`default_nettype wire

// ===== design/lsta_ctrl.sv =====
// controller state machine: accepts a tick, then sequences the led beats
`default_nettype none

module lsta_ctrl
    import lsta_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire lsta_stat_t stat,
    output lsta_cmd_t       cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // next state and commands
    always_comb begin
        state_next    = state_reg;
        cmd.load_head = 1'b0;
        cmd.shift     = 1'b0;
        s_ready       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_head = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.shift = 1'b1;
                    if (stat.at_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/lsta_datapath.sv =====
// datapath: head tracking, rotating intensity line, offset register, output beat register
`default_nettype none

module lsta_datapath
    import lsta_pkg::*;
#(
    parameter int LEDS_PER_SEGMENT = DEF_LEDS_PER_SEGMENT
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_W-1:0]     cfg_wr_data,
    input  wire logic                 s_random_pick,
    input  wire lsta_cmd_t            cmd,
    output lsta_stat_t                stat,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [INDEX_W-1:0]        m_led_index,
    output logic [LEVEL_W-1:0]        m_level,
    output logic                      m_last
);

    localparam int LED_COUNT = NUM_SEGMENTS * LEDS_PER_SEGMENT;
    localparam int IDX_W     = $clog2(LED_COUNT);
    localparam logic [POS_W-1:0] POS_TOP  = POS_W'(LEDS_PER_SEGMENT - 1);
    localparam logic [POS_W-1:0] POS_SPAN = POS_W'(LEDS_PER_SEGMENT);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(LED_COUNT - 1);

    logic [SEG_W-1:0]   seg_reg, seg_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               up_reg, up_next;
    logic [IDX_W-1:0]   lit_idx_reg;
    logic               lit_hit_reg;
    logic [IDX_W-1:0]   cnt_reg;
    logic [CFG_W-1:0]   offset_reg;
    logic [LEVEL_W-1:0] store_reg [LED_COUNT];

    logic               m_valid_reg;
    logic [INDEX_W-1:0] m_led_index_reg;
    logic [LEVEL_W-1:0] m_level_reg;
    logic               m_last_reg;

    logic [IDX_W-1:0]   seg_base;
    logic [IDX_W-1:0]   lit_idx;
    logic               lit_hit;
    logic [POS_W-1:0]   pos_inc;
    logic [LEVEL_W-1:0] new_level;
    hop_t               hop_fwd, hop_rev;

    // led under the head before it moves
    assign seg_base = IDX_W'(seg_reg) * IDX_W'(LEDS_PER_SEGMENT);
    assign lit_idx  = seg_reg[0] ? seg_base + IDX_W'(POS_TOP - pos_reg)
                                 : seg_base + IDX_W'(pos_reg);
    assign lit_hit  = (seg_reg != SEG_NONE) && (pos_reg < POS_SPAN);

    // head movement
    assign hop_fwd = fwd_hop(seg_reg, s_random_pick);
    assign hop_rev = rev_hop(seg_reg, s_random_pick);
    assign pos_inc = pos_reg + POS_W'(1);

    always_comb begin
        seg_next = seg_reg;
        pos_next = pos_reg;
        up_next  = up_reg;
        if (seg_reg == SEG_NONE || (up_reg && pos_inc >= POS_SPAN)) begin
            seg_next = hop_fwd.seg;
            up_next  = hop_fwd.up;
            pos_next = hop_fwd.up ? '0 : POS_TOP;
        end else if (up_reg) begin
            pos_next = pos_inc;
        end else if (pos_reg != '0 && pos_reg < POS_SPAN) begin
            pos_next = pos_reg - POS_W'(1);
        end else begin
            seg_next = hop_rev.seg;
            up_next  = hop_rev.up;
            pos_next = hop_rev.up ? '0 : POS_TOP;
        end
    end

    // head state, lit led and beat counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_reg     <= '0;
            pos_reg     <= '0;
            up_reg      <= 1'b1;
            lit_hit_reg <= 1'b0;
            lit_idx_reg <= '0;
            cnt_reg     <= '0;
        end else if (cmd.load_head) begin
            seg_reg     <= seg_next;
            pos_reg     <= pos_next;
            up_reg      <= up_next;
            lit_hit_reg <= lit_hit;
            lit_idx_reg <= lit_idx;
            cnt_reg     <= '0;
        end else if (cmd.shift) begin
            cnt_reg <= cnt_reg + IDX_W'(1);
        end
    end

    // glyph offset register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
        end else if (cfg_wr_en) begin
            offset_reg <= cfg_wr_data;
        end
    end

    // faded or relit level of the led at the front of the line
    assign new_level = (lit_hit_reg && lit_idx_reg == cnt_reg) ? FULL_LEVEL
                                                               : (store_reg[0] >> 1);

    // intensity line rotates once per tick, front entry returns at the back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LED_COUNT; i++) begin
                store_reg[i] <= '0;
            end
        end else if (cmd.shift) begin
            for (int i = 0; i < LED_COUNT - 1; i++) begin
                store_reg[i] <= store_reg[i+1];
            end
            store_reg[LED_COUNT-1] <= new_level;
        end
    end

    // output beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.shift) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.shift) begin
            m_led_index_reg <= INDEX_W'(offset_reg) + INDEX_W'(cnt_reg);
            m_level_reg     <= new_level;
            m_last_reg      <= (cnt_reg == IDX_LAST);
        end
    end

    assign stat.at_last  = (cnt_reg == IDX_LAST);
    assign stat.out_free = !m_valid_reg || m_ready;

    assign m_valid     = m_valid_reg;
    assign m_led_index = m_led_index_reg;
    assign m_level     = m_level_reg;
    assign m_last      = m_last_reg;

endmodule

`default_nettype wire

// ===== design/led_snake_trail_animator.sv =====
// top level of the led snake trail animator
//
//  channel  | ports                                   | direction
//  ---------+-----------------------------------------+----------
//  tick in  | s_valid s_ready s_random_pick           | in
//  led out  | m_valid m_ready m_led_index m_level m_last | out
//  config   | cfg_wr_en cfg_wr_data (glyph offset)    | in
//
// one tick is accepted, then yields 7*LEDS_PER_SEGMENT beats (28 by default), set by the
// intensity line rotating one led per cycle through the output register when not stalled.
// synchronous active-low reset clears the intensities, the head and the offset.
// a stalled m_ready holds the rotation; a new tick is taken once the last beat is issued.
`default_nettype none

module led_snake_trail_animator
    import lsta_pkg::*;
#(
    parameter int LEDS_PER_SEGMENT = DEF_LEDS_PER_SEGMENT
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_W-1:0]     cfg_wr_data,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_random_pick,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [INDEX_W-1:0]        m_led_index,
    output logic [LEVEL_W-1:0]        m_level,
    output logic                      m_last
);

    lsta_cmd_t  cmd;
    lsta_stat_t stat;

    // sequencing
    lsta_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // storage and arithmetic
    lsta_datapath #(
        .LEDS_PER_SEGMENT (LEDS_PER_SEGMENT)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_random_pick (s_random_pick),
        .cmd           (cmd),
        .stat          (stat),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_led_index   (m_led_index),
        .m_level       (m_level),
        .m_last        (m_last)
    );

endmodule

`default_nettype wire

// ===== bench/led_snake_trail_animator_test.sv =====
// self-checking bench for the led snake trail animator: queued ticks, predicted led beats
`default_nettype none

module led_snake_trail_animator_test;
    import lsta_pkg::*;

    localparam int LPS           = 4;
    localparam int LED_TOTAL     = NUM_SEGMENTS * LPS;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 2 * LED_TOTAL + 8;

    // next head per segment and pick, coded as {enters moving up, segment}
    // one-neighbor segments list the same hop twice so the pick drops out
    localparam bit [3:0] LEAVE_TOP [8][2] = '{
        '{4'h1, 4'h3}, '{4'h0, 4'h3}, '{4'h4, 4'h4}, '{4'h1, 4'h0},
        '{4'h2, 4'h2}, '{4'h8, 4'h8}, '{4'h9, 4'hA}, '{4'h8, 4'h8}
    };
    localparam bit [3:0] LEAVE_BOTTOM [8][2] = '{
        '{4'h5, 4'h5}, '{4'hA, 4'h6}, '{4'h9, 4'h6}, '{4'hC, 4'hC},
        '{4'hB, 4'hB}, '{4'hE, 4'hE}, '{4'hD, 4'hD}, '{4'h8, 4'h8}
    };

    typedef struct {
        bit [INDEX_W-1:0] index;
        bit [LEVEL_W-1:0] level;
        bit               last;
    } led_beat_t;

    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               cfg_wr_en     = 1'b0;
    logic [CFG_W-1:0]   cfg_wr_data   = '0;
    logic               s_valid       = 1'b0;
    logic               s_random_pick = 1'b0;
    logic               m_ready       = 1'b0;
    wire logic          s_ready;
    wire logic          m_valid;
    wire logic [INDEX_W-1:0] m_led_index;
    wire logic [LEVEL_W-1:0] m_level;
    wire logic          m_last;

    // predictor state: trail intensities, snake head, glyph offset
    bit [LEVEL_W-1:0] glow [LED_TOTAL] = '{default: '0};
    bit [SEG_W-1:0]   head_seg  = '0;
    bit [POS_W-1:0]   head_pos  = '0;
    bit               head_up   = 1'b1;
    bit [CFG_W-1:0]   glyph_base = '0;

    bit        tick_q [$];
    led_beat_t pending_leds [$];
    led_beat_t want;
    bit        tick_taken    = 1'b0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        quiet_cycles  = 0;
    int        mismatches    = 0;

    led_snake_trail_animator #(
        .LEDS_PER_SEGMENT(LPS)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_random_pick (s_random_pick),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_led_index   (m_led_index),
        .m_level       (m_level),
        .m_last        (m_last)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    // head leaves its segment at the top or bottom end
    task automatic leave_segment(input bit at_top, input bit pick);
        bit [3:0] nxt;
        nxt      = at_top ? LEAVE_TOP[head_seg][pick] : LEAVE_BOTTOM[head_seg][pick];
        head_seg = nxt[2:0];
        head_up  = nxt[3];
        head_pos = head_up ? '0 : POS_W'(LPS - 1);
    endtask

    // one animation tick: fade, light the head, move it, queue every led beat
    task automatic animate_tick(input bit pick);
        int        i;
        int        slot;
        led_beat_t beat;
        for (i = 0; i < LED_TOTAL; i++) glow[i] = glow[i] >> 1;
        if (head_seg < NUM_SEGMENTS && head_pos < LPS) begin
            slot = head_seg * LPS + (head_seg[0] ? LPS - 1 - head_pos : head_pos);
            if (slot < LED_TOTAL) glow[slot] = FULL_LEVEL;
        end
        if (head_seg >= NUM_SEGMENTS) begin
            leave_segment(1'b1, pick);
        end else if (head_up) begin
            head_pos = head_pos + 1'b1;
            if (head_pos >= LPS) leave_segment(1'b1, pick);
        end else if (head_pos > 0 && head_pos < LPS) begin
            head_pos = head_pos - 1'b1;
        end else begin
            leave_segment(1'b0, pick);
        end
        for (i = 0; i < LED_TOTAL; i++) begin
            beat.index = INDEX_W'(glyph_base + i);
            beat.level = glow[i];
            beat.last  = (i == LED_TOTAL - 1);
            pending_leds.push_back(beat);
        end
    endtask

    // tick driver and led receiver, both change on the falling edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || tick_taken) begin
            if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid       <= 1'b1;
                s_random_pick <= tick_q.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor, predictor and watchdog on the rising edge
    always @(posedge aclk) begin
        tick_taken <= s_valid && s_ready;
        if (aresetn && m_valid && m_ready) begin
            if (pending_leds.size() == 0) begin
                report_mismatch($sformatf("unexpected beat index %0d level %0d last %0b",
                                          m_led_index, m_level, m_last));
            end else begin
                want = pending_leds.pop_front();
                if (m_led_index !== want.index)
                    report_mismatch($sformatf("led_index got %0d want %0d",
                                              m_led_index, want.index));
                if (m_level !== want.level)
                    report_mismatch($sformatf("level at index %0d got %0d want %0d",
                                              want.index, m_level, want.level));
                if (m_last !== want.last)
                    report_mismatch($sformatf("last at index %0d got %0b want %0b",
                                              want.index, m_last, want.last));
            end
        end
        if (aresetn && s_valid && s_ready) animate_tick(s_random_pick);

        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one phase: idle mix, offset write while idle, ticks, then drain
    task automatic run_phase(input int send_pct, input int recv_pct,
                             input bit [CFG_W-1:0] offset,
                             input int directed_n, input int random_n);
        int k;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= offset;
        glyph_base   = offset;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        @(posedge aclk);
        // directed picks flip every few ticks so hops see both neighbors
        for (k = 0; k < directed_n; k++) tick_q.push_back(k[2] ^ k[3]);
        for (k = 0; k < random_n; k++) tick_q.push_back(1'($urandom_range(1)));
        do @(posedge aclk);
        while (tick_q.size() != 0 || s_valid || pending_leds.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    // reset, phases, final verdict
    initial begin
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);
        run_phase(29, 73, 8'hFF, 24, 16);
        run_phase(73, 29, 8'h00, 0, 40);
        run_phase(0, 0, CFG_W'($urandom_range(254, 1)), 0, 40);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_leds.size() != 0)
            report_mismatch($sformatf("%0d led beats never arrived", pending_leds.size()));
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
design/lsta_pkg.sv
design/lsta_ctrl.sv
design/lsta_datapath.sv
design/led_snake_trail_animator.sv
bench/led_snake_trail_animator_test.sv
